>>> design/pba_pkg.sv
// pba_pkg: types, constants and lookup functions for proximity_blink_alarm
// no dependencies; used by design/proximity_blink_alarm.sv through scoped names

package pba_pkg;

   // field widths
   localparam int ECHO_W  = 15;
   localparam int AXIS_W  = 16;
   localparam int DIST_W  = 13;
   localparam int CM_W    = 9;
   localparam int INT_W   = 4;
   localparam int HOLD_W  = 16;
   localparam int TOG_W   = 10;
   localparam int THRSQ_W = 26;
   localparam int MAG_W   = 33;
   localparam int EPROD_W = 24;
   localparam int IVP_W   = 18;
   localparam int CNT_W   = 6;

   // fixed-point constants
   localparam logic [EPROD_W-1:0] ECHO_SCALE   = EPROD_W'(281);
   localparam logic [IVP_W-1:0]   IV_SPAN_MS   = IVP_W'(490);
   localparam logic [CM_W-1:0]    IV_MIN_MS    = CM_W'(10);
   localparam logic [CM_W-1:0]    IV_MAX_MS    = CM_W'(500);
   localparam logic [CM_W-1:0]    ALERT_IV_MS  = CM_W'(50);
   localparam logic [DIST_W-1:0]  DIST_MAX_Q4  = {DIST_W{1'b1}};
   localparam logic [HOLD_W-1:0]  ALERT_EL_MAX = {HOLD_W{1'b1}};
   localparam logic [TOG_W-1:0]   TOGGLE_MAX   = {TOG_W{1'b1}};

   // schedule of the shared step counter while an item is worked on
   localparam logic [CNT_W-1:0] CNT_ECHO_LAST   = CNT_W'(ECHO_W - 1);
   localparam logic [CNT_W-1:0] CNT_DIST_COMMIT = CNT_W'(ECHO_W);
   localparam logic [CNT_W-1:0] CNT_IV_LOAD     = CNT_W'(ECHO_W + 1);
   localparam logic [CNT_W-1:0] CNT_IV_FIRST    = CNT_W'(ECHO_W + 2);
   localparam logic [CNT_W-1:0] CNT_IV_LAST     = CNT_W'(ECHO_W + 2 + CM_W - 1);
   localparam logic [CNT_W-1:0] CNT_DIV_LOAD    = CNT_W'(ECHO_W + 2 + CM_W);
   localparam logic [CNT_W-1:0] CNT_DIV_FIRST   = CNT_W'(ECHO_W + 3 + CM_W);
   localparam logic [CNT_W-1:0] CNT_DIV_LAST    = CNT_W'(ECHO_W + 3 + CM_W + IVP_W - 1);
   localparam logic [CNT_W-1:0] CNT_RUN_LAST    = CNT_W'(3 * AXIS_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      REG_NEAR_LIMIT = 2'd0,
      REG_FAR_LIMIT  = 2'd1,
      REG_INTENSITY  = 2'd2,
      REG_ALERT_HOLD = 2'd3
   } reg_index_type;

   // magnitude of a signed axis sample; the most negative value maps to 2^15
   function automatic logic [AXIS_W-1:0] axis_abs(input logic [AXIS_W-1:0] a);
      return a[AXIS_W-1] ? (~a + AXIS_W'(1)) : a;
   endfunction

   // squared crash threshold, (2511 + (10 - intensity) * 384)^2 in Q16
   function automatic logic [THRSQ_W-1:0] thr_sq(input logic [INT_W-1:0] i);
      logic [THRSQ_W-1:0] v;
      case (i)
         4'd0:    v = THRSQ_W'(40335201);
         4'd1:    v = THRSQ_W'(35605089);
         4'd2:    v = THRSQ_W'(31169889);
         4'd3:    v = THRSQ_W'(27029601);
         4'd4:    v = THRSQ_W'(23184225);
         4'd5:    v = THRSQ_W'(19633761);
         4'd6:    v = THRSQ_W'(16378209);
         4'd7:    v = THRSQ_W'(13417569);
         4'd8:    v = THRSQ_W'(10751841);
         4'd9:    v = THRSQ_W'(8381025);
         4'd10:   v = THRSQ_W'(6305121);
         4'd11:   v = THRSQ_W'(4524129);
         4'd12:   v = THRSQ_W'(3038049);
         4'd13:   v = THRSQ_W'(1846881);
         4'd14:   v = THRSQ_W'(950625);
         default: v = THRSQ_W'(349281);
      endcase
      return v;
   endfunction

endpackage

>>> design/proximity_blink_alarm.sv
// proximity_blink_alarm: top level, proximity and crash alarm with bit-serial datapath
// depends on design/pba_pkg.sv (types, constants, threshold table)
//
// usage
//   req channel: one request per millisecond tick; req_tuser flags a fresh sample,
//   req_tdata carries echo time and the three acceleration axes.
//   rsp channel: exactly one response per request with alarm_on and accel_alert.
//   csr port: write near/far limits, intensity and alert hold at 0x0, 0x4, 0x8, 0xc;
//   the user must write only while idle (not enforced); reads return the stored value.
// timing
//   a request is taken only in idle; it then runs on a shared step counter, bounded
//   by the three 16-step shift-add squares of the axes (the echo scaling, the
//   interval multiply and the 18-step restoring divide overlap them), then the
//   finish state writes the response register once it is free. A new request is
//   taken only after the previous one has been written to the response register.
// reset
//   synchronous, active high; limits return to 25/100 cm, intensity 5, hold 1500 ms,
//   distance is out of range and all counters, alert and display are cleared.
// stall
//   a pending response stays in its register; the next request may still be taken
//   and runs, but its result waits before commit until the register is free.

module proximity_blink_alarm (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // echo_us[14:0], accel_x, accel_y, accel_z, zero pad
   input  logic        req_tuser,   // sample_valid
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // alarm_on, accel_alert, zero pad
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ECHO_W  = pba_pkg::ECHO_W;
   localparam int AXIS_W  = pba_pkg::AXIS_W;
   localparam int DIST_W  = pba_pkg::DIST_W;
   localparam int CM_W    = pba_pkg::CM_W;
   localparam int INT_W   = pba_pkg::INT_W;
   localparam int HOLD_W  = pba_pkg::HOLD_W;
   localparam int TOG_W   = pba_pkg::TOG_W;
   localparam int MAG_W   = pba_pkg::MAG_W;
   localparam int EPROD_W = pba_pkg::EPROD_W;
   localparam int IVP_W   = pba_pkg::IVP_W;
   localparam int CNT_W   = pba_pkg::CNT_W;

   // control
   pba_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_data_ff, rsp_data_in;
   logic               out_free;
   logic               accept;
   logic               commit;

   // configuration
   logic [CM_W-1:0]    near_ff, near_in;
   logic [CM_W-1:0]    far_ff, far_in;
   logic [INT_W-1:0]   intensity_ff, intensity_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic               csr_write;
   pba_pkg::reg_index_type csr_index;

   // tick state
   logic [DIST_W-1:0]  distance_ff, distance_in;
   logic               dist_valid_ff, dist_valid_in;
   logic               alert_ff, alert_in;
   logic [HOLD_W-1:0]  alert_el_ff, alert_el_in;
   logic [TOG_W-1:0]   toggle_el_ff, toggle_el_in;
   logic               phase_ff, phase_in;
   logic               level_ff, level_in;

   // per-request working registers
   logic               sample_ff, sample_in;
   logic               echo_nz_ff, echo_nz_in;
   logic [ECHO_W-1:0]  echo_ff, echo_in;
   logic [EPROD_W-1:0] echo_mc_ff, echo_mc_in;
   logic [EPROD_W-1:0] echo_prod_ff, echo_prod_in;
   logic [2*AXIS_W-1:0] axes_ff, axes_in;
   logic [AXIS_W-1:0]  sq_mb_ff, sq_mb_in;
   logic [2*AXIS_W-1:0] sq_mc_ff, sq_mc_in;
   logic signed [MAG_W-1:0] mag_ff, mag_in;
   logic [CM_W-1:0]    iv_mb_ff, iv_mb_in;
   logic [IVP_W-1:0]   iv_mc_ff, iv_mc_in;
   logic [IVP_W-1:0]   work_ff, work_in;
   logic [CM_W-1:0]    rem_ff, rem_in;

   // datapath helpers
   logic [AXIS_W-1:0]  next_axis;
   logic [ECHO_W-1:0]  req_echo;
   logic [AXIS_W-1:0]  req_x;
   logic [DIST_W:0]    dist_raw;
   logic [DIST_W-1:0]  dist_sat;
   logic [CM_W-1:0]    span;
   logic [CM_W:0]      div_shift;
   logic               div_bit;

   // tick decision helpers
   logic [DIST_W-1:0]  near_q4;
   logic [DIST_W-1:0]  far_q4;
   logic [CM_W-1:0]    band_iv;
   logic               trig;
   logic               tk_alert;
   logic [HOLD_W-1:0]  tk_alert_el;
   logic [TOG_W-1:0]   tk_toggle_el;
   logic               tk_phase;
   logic               tk_level;
   logic               tk_blink;
   logic [CM_W-1:0]    tk_iv;

   assign req_tready = (state_ff == pba_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == pba_pkg::ST_FINISH) && out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   assign req_echo = req_tdata[ECHO_W-1:0];
   assign req_x    = req_tdata[ECHO_W +: AXIS_W];

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = pba_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         pba_pkg::REG_NEAR_LIMIT: csr_prdata = {{(32-CM_W){1'b0}}, near_ff};
         pba_pkg::REG_FAR_LIMIT:  csr_prdata = {{(32-CM_W){1'b0}}, far_ff};
         pba_pkg::REG_INTENSITY:  csr_prdata = {{(32-INT_W){1'b0}}, intensity_ff};
         pba_pkg::REG_ALERT_HOLD: csr_prdata = {{(32-HOLD_W){1'b0}}, hold_ff};
         default:                 csr_prdata = 32'b0;
      endcase
   end

   always_comb begin
      near_in      = near_ff;
      far_in       = far_ff;
      intensity_in = intensity_ff;
      hold_in      = hold_ff;
      if (csr_write) begin
         case (csr_index)
            pba_pkg::REG_NEAR_LIMIT: near_in      = csr_pwdata[CM_W-1:0];
            pba_pkg::REG_FAR_LIMIT:  far_in       = csr_pwdata[CM_W-1:0];
            pba_pkg::REG_INTENSITY:  intensity_in = csr_pwdata[INT_W-1:0];
            pba_pkg::REG_ALERT_HOLD: hold_in      = csr_pwdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         pba_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pba_pkg::ST_RUN;
               cnt_in   = '0;
            end
         end
         pba_pkg::ST_RUN: begin
            if (cnt_ff == pba_pkg::CNT_RUN_LAST) begin
               state_in = pba_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         pba_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = pba_pkg::ST_IDLE;
            end
         end
         default: state_in = pba_pkg::ST_IDLE;
      endcase
   end

   // serial datapath
   assign next_axis = pba_pkg::axis_abs(axes_ff[AXIS_W-1:0]);
   assign dist_raw  = echo_prod_ff[EPROD_W-1:10];
   assign dist_sat  = dist_raw[DIST_W] ? pba_pkg::DIST_MAX_Q4 : dist_raw[DIST_W-1:0];
   assign span      = far_ff - near_ff;
   assign div_shift = {rem_ff, work_ff[IVP_W-1]};
   assign div_bit   = (div_shift >= {1'b0, span});

   always_comb begin
      sample_in    = sample_ff;
      echo_nz_in   = echo_nz_ff;
      echo_in      = echo_ff;
      echo_mc_in   = echo_mc_ff;
      echo_prod_in = echo_prod_ff;
      axes_in      = axes_ff;
      sq_mb_in     = sq_mb_ff;
      sq_mc_in     = sq_mc_ff;
      mag_in       = mag_ff;
      iv_mb_in     = iv_mb_ff;
      iv_mc_in     = iv_mc_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      distance_in  = distance_ff;
      dist_valid_in = dist_valid_ff;

      if (accept) begin
         sample_in    = req_tuser;
         echo_nz_in   = (req_echo != '0);
         echo_in      = req_echo;
         echo_mc_in   = pba_pkg::ECHO_SCALE;
         echo_prod_in = '0;
         axes_in      = req_tdata[ECHO_W+AXIS_W +: 2*AXIS_W];
         sq_mb_in     = pba_pkg::axis_abs(req_x);
         sq_mc_in     = {{AXIS_W{1'b0}}, pba_pkg::axis_abs(req_x)};
         // start from minus the squared threshold so the sign tells the compare
         mag_in       = -$signed({{(MAG_W-pba_pkg::THRSQ_W){1'b0}},
                                  pba_pkg::thr_sq(intensity_ff)});
      end else if (state_ff == pba_pkg::ST_RUN) begin
         // sum of squares, one multiplier bit per step, axes in turn
         if (sq_mb_ff[0]) begin
            mag_in = mag_ff + $signed({1'b0, sq_mc_ff});
         end
         if (cnt_ff[3:0] == 4'hF) begin
            sq_mb_in = next_axis;
            sq_mc_in = {{AXIS_W{1'b0}}, next_axis};
            axes_in  = {{AXIS_W{1'b0}}, axes_ff[2*AXIS_W-1:AXIS_W]};
         end else begin
            sq_mb_in = sq_mb_ff >> 1;
            sq_mc_in = sq_mc_ff << 1;
         end

         // echo scaling to 1/16 cm
         if (cnt_ff <= pba_pkg::CNT_ECHO_LAST) begin
            if (echo_ff[0]) begin
               echo_prod_in = echo_prod_ff + echo_mc_ff;
            end
            echo_in    = echo_ff >> 1;
            echo_mc_in = echo_mc_ff << 1;
         end

         if (cnt_ff == pba_pkg::CNT_DIST_COMMIT && sample_ff) begin
            distance_in   = dist_sat;
            dist_valid_in = echo_nz_ff;
         end

         // blink interval: (cm - near) * 490, then divide by the band span
         if (cnt_ff == pba_pkg::CNT_IV_LOAD) begin
            iv_mb_in = distance_ff[DIST_W-1:4] - near_ff;
            iv_mc_in = pba_pkg::IV_SPAN_MS;
            work_in  = '0;
         end
         if (cnt_ff >= pba_pkg::CNT_IV_FIRST && cnt_ff <= pba_pkg::CNT_IV_LAST) begin
            if (iv_mb_ff[0]) begin
               work_in = work_ff + iv_mc_ff;
            end
            iv_mb_in = iv_mb_ff >> 1;
            iv_mc_in = iv_mc_ff << 1;
         end
         if (cnt_ff == pba_pkg::CNT_DIV_LOAD) begin
            rem_in = '0;
         end
         if (cnt_ff >= pba_pkg::CNT_DIV_FIRST && cnt_ff <= pba_pkg::CNT_DIV_LAST) begin
            rem_in  = div_bit ? CM_W'(div_shift - {1'b0, span}) : div_shift[CM_W-1:0];
            work_in = {work_ff[IVP_W-2:0], div_bit};
         end
      end
   end

   // tick decision, applied when the response register can take it
   assign near_q4 = {near_ff, 4'b0};
   assign far_q4  = {far_ff, 4'b0};
   assign band_iv = (work_ff > IVP_W'(pba_pkg::IV_MAX_MS - pba_pkg::IV_MIN_MS))
                    ? pba_pkg::IV_MAX_MS : work_ff[CM_W-1:0] + pba_pkg::IV_MIN_MS;
   assign trig    = !mag_ff[MAG_W-1] && (mag_ff != '0);

   always_comb begin
      tk_alert_el  = (alert_el_ff != pba_pkg::ALERT_EL_MAX) ? alert_el_ff + HOLD_W'(1)
                                                            : alert_el_ff;
      tk_toggle_el = (toggle_el_ff != pba_pkg::TOGGLE_MAX) ? toggle_el_ff + TOG_W'(1)
                                                           : toggle_el_ff;
      tk_alert     = alert_ff;
      tk_phase     = phase_ff;
      tk_level     = level_ff;
      tk_blink     = 1'b0;
      tk_iv        = pba_pkg::ALERT_IV_MS;

      if (sample_ff && trig) begin
         tk_alert    = 1'b1;
         tk_alert_el = '0;
      end

      if (tk_alert) begin
         if (tk_alert_el < hold_ff) begin
            tk_blink = 1'b1;
         end else begin
            tk_alert = 1'b0;
            tk_level = 1'b0;
         end
      end else if (dist_valid_ff && distance_ff <= near_q4) begin
         tk_level = 1'b1;
      end else if (dist_valid_ff && distance_ff <= far_q4) begin
         tk_blink = 1'b1;
         tk_iv    = band_iv;
      end else begin
         tk_level = 1'b0;
      end

      if (tk_blink && tk_toggle_el >= {1'b0, tk_iv}) begin
         tk_toggle_el = '0;
         tk_phase     = !phase_ff;
         tk_level     = !phase_ff;
      end
   end

   always_comb begin
      alert_in     = alert_ff;
      alert_el_in  = alert_el_ff;
      toggle_el_in = toggle_el_ff;
      phase_in     = phase_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         alert_in     = tk_alert;
         alert_el_in  = tk_alert_el;
         toggle_el_in = tk_toggle_el;
         phase_in     = tk_phase;
         level_in     = tk_level;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {tk_alert, tk_level};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pba_pkg::ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         near_ff       <= CM_W'(25);
         far_ff        <= CM_W'(100);
         intensity_ff  <= INT_W'(5);
         hold_ff       <= HOLD_W'(1500);
         distance_ff   <= '0;
         dist_valid_ff <= 1'b0;
         alert_ff      <= 1'b0;
         alert_el_ff   <= '0;
         toggle_el_ff  <= '0;
         phase_ff      <= 1'b0;
         level_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         near_ff       <= near_in;
         far_ff        <= far_in;
         intensity_ff  <= intensity_in;
         hold_ff       <= hold_in;
         distance_ff   <= distance_in;
         dist_valid_ff <= dist_valid_in;
         alert_ff      <= alert_in;
         alert_el_ff   <= alert_el_in;
         toggle_el_ff  <= toggle_el_in;
         phase_ff      <= phase_in;
         level_ff      <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      sample_ff    <= sample_in;
      echo_nz_ff   <= echo_nz_in;
      echo_ff      <= echo_in;
      echo_mc_ff   <= echo_mc_in;
      echo_prod_ff <= echo_prod_in;
      axes_ff      <= axes_in;
      sq_mb_ff     <= sq_mb_in;
      sq_mc_ff     <= sq_mc_in;
      mag_ff       <= mag_in;
      iv_mb_ff     <= iv_mb_in;
      iv_mc_ff     <= iv_mc_in;
      work_ff      <= work_in;
      rem_ff       <= rem_in;
   end

   // checks
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == pba_pkg::ST_RUN && cnt_ff == '0))
      else $error("request taken but sequencer did not start");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::ST_RUN) |-> (cnt_ff <= pba_pkg::CNT_RUN_LAST))
      else $error("step counter past last step");

   a_commit_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("commit did not raise response valid");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(commit))
      else $error("response valid rose without a commit");

endmodule
